// File: rtl/core/madf_pkg.sv
// Shared types, constants and the sine evaluation for the modulated allpass core.
// No dependencies; every other file in rtl/core imports this package.
package madf_pkg;

  // configuration port
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_INT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_FRAC = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_ENABLE = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_DEPTH  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_STEP   = 3'd5;

  // register widths and reset values
  localparam int GAIN_BITS  = 16;
  localparam int DINT_BITS  = 14;
  localparam int FRAC_BITS  = 16;
  localparam int DEPTH_BITS = 16;
  localparam int PHASE_BITS = 16;

  localparam logic signed [GAIN_BITS-1:0] GAIN_RESET = 16'sd22938;

  // delay in Q16 samples, signed, wide enough for a 65536 deep line plus excursion
  localparam int DLY_BITS = 34;

  // depth (16 bit unsigned) times Q1.15 sine
  localparam int EXC_PROD_BITS = 33;

  // sine polynomial coefficients, Q16
  localparam longint SIN_A = 102944;
  localparam longint SIN_B = 42048;
  localparam longint SIN_C = 4640;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_NEWER,
    S_INTERP,
    S_NODE,
    S_OUT
  } state_t;

  // Q1.15 sine of an angle given in 1/65536 of a cycle, evaluated on the quarter wave
  function automatic logic signed [15:0] sine_of_angle(input logic [15:0] angle);
    logic [1:0] quad;
    longint     z;
    longint     z2;
    longint     t;
    longint     s;
    quad = angle[15:14];
    z    = longint'(angle[13:0]);
    if (quad[0]) begin
      z = 64'sd16384 - z;
    end
    z2 = (z * z) >>> 14;
    t  = (SIN_C * z2) >>> 14;
    t  = SIN_B - t;
    t  = (t * z2) >>> 14;
    t  = SIN_A - t;
    s  = ((t * z) >>> 14) >>> 1;
    if (s > 64'sd32767) begin
      s = 64'sd32767;
    end
    return quad[1] ? -16'(s) : 16'(s);
  endfunction

endpackage

// File: rtl/core/madf_sine_rom.sv
// Sine lookup table with registered read, indexed by the modulation phase.
// Depends on madf_pkg for sine_of_angle.
module madf_sine_rom #(
  parameter int SINE_ENTRIES = 256
) (
  input  logic                                clk,
  input  logic [madf_pkg::PHASE_BITS-1:0]     phase,
  output logic signed [15:0]                  sine_q
);
  import madf_pkg::*;

  localparam int IW = $clog2(SINE_ENTRIES);

  logic signed [15:0] rom [SINE_ENTRIES];
  logic [31:0]        idx_wide;
  logic [IW-1:0]      idx;

  for (genvar i = 0; i < SINE_ENTRIES; i++) begin : g_rom
    localparam int ANGLE = (i * 65536) / SINE_ENTRIES;
    assign rom[i] = sine_of_angle(ANGLE[15:0]);
  end

  assign idx_wide = (32'(phase) * 32'(SINE_ENTRIES)) >> PHASE_BITS;
  assign idx      = idx_wide[IW-1:0];

  always_ff @(posedge clk) begin
    sine_q <= rom[idx];
  end

endmodule

// File: rtl/core/madf_delay_ram.sv
// Delay line storage: one write port, one registered read port.
// Entries at or above the fill count read as zero, which stands in for clearing at reset.
// Depends on madf_pkg only by convention; no package items used beyond the import.
module madf_delay_ram #(
  parameter int DEPTH     = 16384,
  parameter int DATA_BITS = 24,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);
  import madf_pkg::*;

  localparam logic [AW:0] DEPTH_A = (AW+1)'(DEPTH);

  logic [DATA_BITS-1:0] mem [DEPTH];
  logic [DATA_BITS-1:0] mem_q_r;
  logic                 hit_r;
  logic [AW:0]          fill_r;

  // writes walk the line in order from entry zero, so a count is enough
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (wr_en && (fill_r != DEPTH_A)) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      hit_r   <= ({1'b0, rd_addr} < fill_r);
    end
  end

  assign rd_data = hit_r ? mem_q_r : '0;

endmodule

// File: rtl/core/modulated_allpass_delay_filter_core.sv
// Top level of the modulated Schroeder allpass: config registers, sequencer, datapath.
// Depends on madf_pkg, madf_sine_rom and madf_delay_ram.
//
//   channel  | ports                                  | direction
//   ---------+----------------------------------------+----------
//   input    | in_valid, in_ready, in_sample          | in
//   result   | out_valid, out_ready, out_sample       | out
//   config   | cfg_wr_en, cfg_index, cfg_data         | in
//
// The sequencer handles one sample at a time: it steps through S_ADDR, S_NEWER,
// S_INTERP, S_NODE and S_OUT between the input transfer and the output register,
// and takes no new sample until it is back in S_IDLE; the two reads of the single
// delay RAM port plus the three chained multiplies set that pace.
// Synchronous active-low reset; the delay line reads as zero until each entry is
// written, so no clearing pass is needed and samples are taken right after reset.
// A held output stalls the sequencer in its last state; the next sample is taken
// while the finished one waits in the output register.
module modulated_allpass_delay_filter_core #(
  parameter int DELAY_DEPTH  = 16384,
  parameter int SINE_ENTRIES = 256,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_BITS-1:0]        out_sample,
  input  logic                                 cfg_wr_en,
  input  logic [madf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [madf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import madf_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  localparam int SB = SAMPLE_BITS;
  localparam int IW = SB + 19;   // interpolation accumulator
  localparam int GW = SB + 18;   // gain product and sum

  localparam logic signed [DLY_BITS-1:0] DMAX =
    DLY_BITS'(longint'(DELAY_DEPTH) * 64'sd65536 - 64'sd1);
  localparam logic [AW:0]    DEPTH_A = (AW+1)'(DELAY_DEPTH);
  localparam logic [AW-1:0]  LAST_A  = AW'(DELAY_DEPTH - 1);
  localparam logic signed [GW-1:0] SMAX = GW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [GW-1:0] SMIN = -SMAX - GW'(1);

  // configuration registers
  logic signed [GAIN_BITS-1:0] gain_r;
  logic [DINT_BITS-1:0]        delay_int_r;
  logic [FRAC_BITS-1:0]        delay_frac_r;
  logic                        mod_enable_r;
  logic [DEPTH_BITS-1:0]       mod_depth_r;
  logic [PHASE_BITS-1:0]       mod_step_r;

  // control state
  state_t                      state_r, state_nxt;
  logic [PHASE_BITS-1:0]       mod_phase_r;
  logic [AW-1:0]               wr_idx_r;
  logic                        out_valid_r;

  // payload
  logic signed [SB-1:0]        x_r;
  logic signed [SB-1:0]        newer_r;
  logic signed [SB-1:0]        v_r;
  logic signed [SB-1:0]        node_r;
  logic signed [SB-1:0]        out_sample_r;
  logic [FRAC_BITS-1:0]        f_r;
  logic [AW-1:0]               older_r;
  logic signed [EXC_PROD_BITS-1:0] exc_prod_r;

  // sine and memory
  logic signed [15:0]          sine_q;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;
  logic [SB-1:0]               rd_data;
  logic                        wr_en;
  logic                        out_go;

  // delay computation
  logic signed [DLY_BITS-1:0]  d_base;
  logic signed [EXC_PROD_BITS-1:0] exc_round;
  logic signed [DLY_BITS-1:0]  d_sum;
  logic signed [DLY_BITS-1:0]  d_mod;
  logic signed [DLY_BITS-1:0]  d_lim;
  logic                        mod_act;
  logic [AW-1:0]               k;
  logic [AW:0]                 newer_ext;
  logic [AW-1:0]               newer_a;
  logic [AW-1:0]               older_a;

  // interpolation
  logic signed [IW-1:0]        diff;
  logic signed [IW-1:0]        iprod;
  logic signed [IW-1:0]        iacc;
  logic signed [IW-1:0]        ishift;
  logic signed [SB-1:0]        node_val;
  logic signed [SB-1:0]        y_val;

  // base +/- round(g * m) saturated to the sample range
  function automatic logic signed [SB-1:0] gain_sat(
    input logic signed [SB-1:0]        base,
    input logic signed [SB-1:0]        m,
    input logic signed [GAIN_BITS-1:0] g,
    input logic                        sub
  );
    logic signed [GW-1:0] gp;
    logic signed [GW-1:0] r;
    logic signed [GW-1:0] s;
    gp = GW'(g) * GW'(m);
    r  = (gp + GW'(16384)) >>> 15;
    s  = sub ? (GW'(base) - r) : (GW'(base) + r);
    if (s > SMAX) begin
      return SMAX[SB-1:0];
    end else if (s < SMIN) begin
      return SMIN[SB-1:0];
    end
    return s[SB-1:0];
  endfunction

  madf_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine (
    .clk    (clk),
    .phase  (mod_phase_r),
    .sine_q (sine_q)
  );

  madf_delay_ram #(
    .DEPTH     (DELAY_DEPTH),
    .DATA_BITS (SB),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_idx_r),
    .wr_data (node_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r       <= GAIN_RESET;
      delay_int_r  <= '0;
      delay_frac_r <= '0;
      mod_enable_r <= 1'b0;
      mod_depth_r  <= '0;
      mod_step_r   <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_GAIN:       gain_r       <= $signed(cfg_data[GAIN_BITS-1:0]);
        CFG_DELAY_INT:  delay_int_r  <= cfg_data[DINT_BITS-1:0];
        CFG_DELAY_FRAC: delay_frac_r <= cfg_data[FRAC_BITS-1:0];
        CFG_MOD_ENABLE: mod_enable_r <= cfg_data[0];
        CFG_MOD_DEPTH:  mod_depth_r  <= cfg_data[DEPTH_BITS-1:0];
        CFG_MOD_STEP:   mod_step_r   <= cfg_data[PHASE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // excursion product follows the phase; it settles long before the next sample
  always_ff @(posedge clk) begin
    exc_prod_r <= $signed({1'b0, mod_depth_r}) * EXC_PROD_BITS'(sine_q);
  end

  // read delay and tap addresses
  always_comb begin
    d_base    = $signed({{(DLY_BITS-DINT_BITS-FRAC_BITS){1'b0}}, delay_int_r, delay_frac_r});
    exc_round = (exc_prod_r + EXC_PROD_BITS'(64)) >>> 7;
    mod_act   = mod_enable_r && (d_base != '0);
    d_sum     = d_base + DLY_BITS'(exc_round);
    if (mod_act) begin
      d_mod = (d_sum < 0) ? '0 : d_sum;
    end else begin
      d_mod = d_base;
    end
    d_lim = (d_mod > DMAX) ? DMAX : d_mod;
    k     = d_lim[FRAC_BITS +: AW];
    if ({1'b0, wr_idx_r} >= {1'b0, k}) begin
      newer_ext = {1'b0, wr_idx_r} - {1'b0, k};
    end else begin
      newer_ext = {1'b0, wr_idx_r} + DEPTH_A - {1'b0, k};
    end
    newer_a = newer_ext[AW-1:0];
    older_a = (newer_a == '0) ? LAST_A : newer_a - 1'b1;
  end

  // v = newer + (older - newer) * f, rounded
  always_comb begin
    diff   = IW'($signed(rd_data)) - IW'(newer_r);
    iprod  = diff * IW'($signed({1'b0, f_r}));
    iacc   = (IW'(newer_r) <<< 16) + iprod + IW'(32768);
    ishift = iacc >>> 16;
  end

  assign node_val = gain_sat(x_r, v_r, gain_r, 1'b0);
  assign y_val    = gain_sat(v_r, node_r, gain_r, 1'b1);

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = newer_a;
    wr_en     = 1'b0;
    out_go    = !out_valid_r || out_ready;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR: begin
        rd_en     = 1'b1;
        state_nxt = S_NEWER;
      end
      S_NEWER: begin
        rd_en     = 1'b1;
        rd_addr   = older_r;
        state_nxt = S_INTERP;
      end
      S_INTERP: state_nxt = S_NODE;
      S_NODE:   state_nxt = S_OUT;
      S_OUT: begin
        // hold until the output register is free
        if (out_go) begin
          wr_en     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_phase_r <= '0;
      wr_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_ADDR) && mod_act) begin
        mod_phase_r <= mod_phase_r + mod_step_r;
      end
      if (wr_en) begin
        wr_idx_r <= (wr_idx_r == LAST_A) ? '0 : wr_idx_r + 1'b1;
      end
      if (wr_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      x_r <= in_sample;
    end
    if (state_r == S_ADDR) begin
      f_r     <= d_lim[FRAC_BITS-1:0];
      older_r <= older_a;
    end
    if (state_r == S_NEWER) begin
      newer_r <= $signed(rd_data);
    end
    if (state_r == S_INTERP) begin
      // a delay below one sample passes the input straight through
      v_r <= (delay_int_r == '0) ? x_r : ishift[SB-1:0];
    end
    if (state_r == S_NODE) begin
      node_r <= node_val;
    end
    if (wr_en) begin
      out_sample_r <= y_val;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// File: tb/tb_modulated_allpass_delay_filter_core.sv
// Self-checking bench for modulated_allpass_delay_filter_core: directed and random samples
// over several register settings, checked by an in-bench model of the allpass.
// Depends on madf_pkg and the core RTL; needs nothing else.
`timescale 1ns / 100ps

module tb_modulated_allpass_delay_filter_core;

  localparam int LINE_DEPTH = 16384;
  localparam int SINE_N     = 256;
  localparam int SAMPLE_W   = 24;

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN = 24'sh800000;

  // indexes past the register list; writes to them must change nothing
  localparam logic [madf_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_A = 3'd6;
  localparam logic [madf_pkg::CFG_IDX_BITS-1:0] CFG_UNUSED_B = 3'd7;

  localparam int RANDOM_ITEMS = 500;

  class allpass_scoreboard;
    int                        line_mem [LINE_DEPTH];
    int unsigned               wr_ptr;
    logic [15:0]               phase_acc;
    int                        gain_q15;
    int unsigned               dly_int;
    int unsigned               dly_frac;
    bit                        mod_on;
    int unsigned               depth_q8;
    logic [15:0]               phase_step;
    logic signed [SAMPLE_W-1:0] expected_q [$];
    int                        mismatches;
    int                        checked;
    int                        noted;

    function new();
      foreach (line_mem[i]) line_mem[i] = 0;
      wr_ptr     = 0;
      phase_acc  = '0;
      gain_q15   = int'(madf_pkg::GAIN_RESET);
      dly_int    = 0;
      dly_frac   = 0;
      mod_on     = 1'b0;
      depth_q8   = 0;
      phase_step = '0;
      mismatches = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // shift right with rounding to nearest, ties toward plus infinity
    function longint rnd_shr(longint x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint clip_sample(longint x);
      if (x > longint'(SMP_MAX)) return longint'(SMP_MAX);
      if (x < longint'(SMP_MIN)) return longint'(SMP_MIN);
      return x;
    endfunction

    function longint sine_q15(logic [15:0] ph);
      longint     idx;
      longint     ang;
      longint     z;
      longint     z2;
      longint     t;
      longint     s;
      logic [1:0] quad;
      idx  = (longint'(ph) * SINE_N) >>> 16;
      ang  = (idx * 65536) / SINE_N;
      quad = 2'((ang >>> 14) & 3);
      z    = ang & 64'h3FFF;
      if (quad[0]) z = 16384 - z;
      z2 = (z * z) >>> 14;
      t  = (madf_pkg::SIN_C * z2) >>> 14;
      t  = madf_pkg::SIN_B - t;
      t  = (t * z2) >>> 14;
      t  = madf_pkg::SIN_A - t;
      s  = ((t * z) >>> 14) >>> 1;
      if (s > 32767) s = 32767;
      return quad[1] ? -s : s;
    endfunction

    function void cfg_write(logic [madf_pkg::CFG_IDX_BITS-1:0] idx,
                            logic [madf_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        madf_pkg::CFG_GAIN:       gain_q15   = int'($signed(data));
        madf_pkg::CFG_DELAY_INT:  dly_int    = int'(data[13:0]);
        madf_pkg::CFG_DELAY_FRAC: dly_frac   = int'(data);
        madf_pkg::CFG_MOD_ENABLE: mod_on     = data[0];
        madf_pkg::CFG_MOD_DEPTH:  depth_q8   = int'(data);
        madf_pkg::CFG_MOD_STEP:   phase_step = data;
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [SAMPLE_W-1:0] smp);
      longint      x;
      longint      d;
      longint      d_max;
      longint      f;
      longint      v;
      longint      node;
      longint      y;
      int unsigned k;
      int unsigned newer;
      int unsigned older;
      x = longint'(smp);
      d = (longint'(dly_int) << 16) | longint'(dly_frac);
      if (mod_on && d != 0) begin
        d = d + rnd_shr(longint'(depth_q8) * sine_q15(phase_acc), 7);
        if (d < 0) d = 0;
        phase_acc = phase_acc + phase_step;
      end
      d_max = (longint'(LINE_DEPTH - 1) << 16) | 64'hFFFF;
      if (d > d_max) d = d_max;
      if (dly_int == 0) begin
        v = x;
      end else begin
        k     = int'(d >>> 16);
        f     = d & 64'hFFFF;
        newer = (wr_ptr + LINE_DEPTH - k) % LINE_DEPTH;
        older = (wr_ptr + 2 * LINE_DEPTH - k - 1) % LINE_DEPTH;
        v = rnd_shr(longint'(line_mem[older]) * f + longint'(line_mem[newer]) * (65536 - f), 16);
      end
      node = clip_sample(x + rnd_shr(longint'(gain_q15) * v, 15));
      y    = clip_sample(v - rnd_shr(longint'(gain_q15) * node, 15));
      line_mem[wr_ptr] = int'(node);
      wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      expected_q.push_back(SAMPLE_W'(y));
      noted++;
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] got);
      logic signed [SAMPLE_W-1:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected output transfer, out_sample=%0d", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: out_sample mismatch on result %0d: expected %0d, got %0d",
                   $time, checked, want, got);
      end
    endfunction
  endclass

  logic                                 clk;
  logic                                 rst_n;
  logic                                 in_valid;
  logic                                 in_ready;
  logic signed [SAMPLE_W-1:0]           in_sample;
  logic                                 out_valid;
  logic                                 out_ready;
  logic signed [SAMPLE_W-1:0]           out_sample;
  logic                                 cfg_wr_en;
  logic [madf_pkg::CFG_IDX_BITS-1:0]    cfg_index;
  logic [madf_pkg::CFG_DATA_BITS-1:0]   cfg_data;

  allpass_scoreboard sb;
  bit                no_gaps;
  int                cfg_writes;
  int                sink_stall;
  int                phases;

  modulated_allpass_delay_filter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("timeout with %0d results still outstanding", sb.pending());
    $display("** modulated_allpass_delay_filter_core: FAILED **");
    $finish;
  end

  // mostly short idle runs, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_sample);
      if (in_valid && in_ready) sb.note_input(in_sample);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_stall > 0) begin
      out_ready <= 1'b0;
      sink_stall = sink_stall - 1;
    end else begin
      sink_stall = pick_gap();
      if (sink_stall > 0) begin
        out_ready <= 1'b0;
        sink_stall = sink_stall - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // called on a falling edge; returns on the falling edge after the transfer
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= smp;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [madf_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [madf_pkg::CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.cfg_write(idx, data);
    cfg_writes++;
    @(negedge clk);
  endtask

  // drop valid, let every result come back, then allow for the pipeline
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return SMP_MAX;
    if (r < 8) return SMP_MIN;
    if (r < 10) return '0;
    if (r < 12) return '1;
    if (r < 40) return SAMPLE_W'($urandom_range(0, 4000)) - 24'sd2000;
    return SAMPLE_W'($urandom());
  endfunction

  task automatic random_setup();
    int          r;
    logic [15:0] val;
    r = $urandom_range(0, 99);
    if (r < 5) val = 16'h7FFF;
    else if (r < 10) val = 16'h8000;
    else if (r < 13) val = 16'h0000;
    else val = 16'($urandom());
    write_reg(madf_pkg::CFG_GAIN, val);

    r = $urandom_range(0, 99);
    if (r < 15) val = 16'd0;
    else if (r < 22) val = 16'd16383;
    else if (r < 27) val = 16'($urandom_range(16300, 16383));
    else val = 16'($urandom_range(1, 40));
    // upper bits are outside the register; set them now and then
    if ($urandom_range(0, 4) == 0) val[15:14] = 2'($urandom());
    write_reg(madf_pkg::CFG_DELAY_INT, val);

    r = $urandom_range(0, 99);
    if (r < 20) val = 16'd0;
    else if (r < 30) val = 16'hFFFF;
    else val = 16'($urandom());
    write_reg(madf_pkg::CFG_DELAY_FRAC, val);

    r = $urandom_range(0, 99);
    if (r < 55) val = 16'd1;
    else if (r < 65) val = 16'($urandom()) & 16'hFFFE;
    else val = 16'd0;
    write_reg(madf_pkg::CFG_MOD_ENABLE, val);

    r = $urandom_range(0, 99);
    if (r < 15) val = 16'd0;
    else if (r < 25) val = 16'hFFFF;
    else if (r < 75) val = 16'($urandom_range(0, 4096));
    else val = 16'($urandom());
    write_reg(madf_pkg::CFG_MOD_DEPTH, val);

    r = $urandom_range(0, 99);
    if (r < 10) val = 16'd0;
    else if (r < 20) val = 16'hFFFF;
    else val = 16'($urandom());
    write_reg(madf_pkg::CFG_MOD_STEP, val);

    if ($urandom_range(0, 3) == 0)
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_A : CFG_UNUSED_B, 16'($urandom()));
  endtask

  initial begin
    int count;
    sb         = new();
    no_gaps    = 1'b0;
    cfg_writes = 0;
    sink_stall = 0;
    phases     = 0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_sample  = '0;
    out_ready  = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: delay below one sample, so the input feeds itself
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample('0);
    send_sample('1);
    send_sample(24'sd1);
    wait_idle();

    // one-sample delay at full positive gain drives the node into saturation
    write_reg(madf_pkg::CFG_GAIN, 16'h7FFF);
    write_reg(madf_pkg::CFG_DELAY_INT, 16'd1);
    send_sample(SMP_MAX);
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(SMP_MIN);
    wait_idle();

    // most negative gain with the largest fraction
    write_reg(madf_pkg::CFG_GAIN, 16'h8000);
    write_reg(madf_pkg::CFG_DELAY_INT, 16'd2);
    write_reg(madf_pkg::CFG_DELAY_FRAC, 16'hFFFF);
    send_sample(SMP_MIN);
    send_sample(SMP_MAX);
    send_sample(24'sd12345);
    send_sample('1);
    wait_idle();

    // writes past the register list, then a deep swing that clamps the delay at zero
    write_reg(CFG_UNUSED_A, 16'hFFFF);
    write_reg(CFG_UNUSED_B, 16'h1234);
    write_reg(madf_pkg::CFG_GAIN, 16'd22938);
    write_reg(madf_pkg::CFG_DELAY_INT, 16'd3);
    write_reg(madf_pkg::CFG_DELAY_FRAC, 16'h8000);
    write_reg(madf_pkg::CFG_MOD_ENABLE, 16'd1);
    write_reg(madf_pkg::CFG_MOD_DEPTH, 16'hFFFF);
    write_reg(madf_pkg::CFG_MOD_STEP, 16'h4000);
    repeat (4) send_sample(SAMPLE_W'($urandom()));
    wait_idle();

    // longest delay at the end of the line, shortened by the excursion; phase steps back by one
    write_reg(madf_pkg::CFG_DELAY_INT, 16'd16383);
    write_reg(madf_pkg::CFG_DELAY_FRAC, 16'hFFFF);
    write_reg(madf_pkg::CFG_MOD_DEPTH, 16'h0400);
    write_reg(madf_pkg::CFG_MOD_STEP, 16'hFFFF);
    repeat (3) send_sample(SAMPLE_W'($urandom()));
    wait_idle();

    // fractional-only delay: input passes through while the phase still advances
    write_reg(madf_pkg::CFG_DELAY_INT, 16'd0);
    write_reg(madf_pkg::CFG_DELAY_FRAC, 16'h1234);
    write_reg(madf_pkg::CFG_MOD_STEP, 16'h0321);
    repeat (3) send_sample(SAMPLE_W'($urandom()));
    wait_idle();

    count = 0;
    while (count < RANDOM_ITEMS) begin
      int n;
      random_setup();
      no_gaps = ($urandom_range(0, 4) == 0);
      n = $urandom_range(35, 65);
      repeat (n) send_sample(pick_sample());
      count += n;
      phases++;
      wait_idle();
      no_gaps = 1'b0;
    end

    repeat (20) @(negedge clk);
    $display("covered %0d samples and %0d results over %0d random settings, %0d register writes",
             sb.noted, sb.checked, phases, cfg_writes);
    $display("mismatches: %0d, results outstanding: %0d", sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** modulated_allpass_delay_filter_core: PASSED **");
    end else begin
      $display("** modulated_allpass_delay_filter_core: FAILED **");
    end
    $finish;
  end

endmodule
